// ===== sv/ppoc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppoc_pkg
// Register indexes, enable bit positions and the divider step shared by the
// pixel point operation chain.
// ----------------------------------------------------------------------------
package ppoc_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned EN_W    = 6;
    localparam int unsigned BIAS_W  = 14;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [PIX_W-1:0] PIXEL_MAX = 8'd255;

    typedef logic [PIX_W-1:0] pix_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OP_ENABLES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_BIAS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN     = 3'd6;

    // op_enables bit positions
    localparam int unsigned EN_INVERT = 0;
    localparam int unsigned EN_THRESH = 1;
    localparam int unsigned EN_RANGE  = 2;
    localparam int unsigned EN_WINDOW = 3;
    localparam int unsigned EN_CLIP   = 4;
    localparam int unsigned EN_SCALE  = 5;

    // One restoring division step on {remainder, numerator/quotient}.
    // The remainder stays below the divisor, so eight bits hold it.
    function automatic logic [2*PIX_W-1:0] div_step(input logic [2*PIX_W-1:0] rq,
                                                    input pix_t d);
        logic [PIX_W:0]   t;
        logic [PIX_W:0]   diff;
        logic [2*PIX_W-1:0] res;
        t    = {rq[2*PIX_W-1:PIX_W], rq[PIX_W-1]};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            res = {diff[PIX_W-1:0], rq[PIX_W-2:0], 1'b1};
        end
        else
        begin
            res = {t[PIX_W-1:0], rq[PIX_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pixel_point_operation_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_point_operation_chain
// Per-pixel invert, threshold, range, window, clip and fixed-point scale.
// ----------------------------------------------------------------------------
// Nine-stage pipeline taking one pixel per clock while the output side does
// not stall. Stage 1 applies invert, threshold and range, stage 2 clamps and
// forms the two window products, stages 3 to 6 run the window division two
// quotient bits each, stage 7 selects the window result, clips and adds the
// scale bias, stage 8 multiplies by the gain and stage 9 saturates into the
// output register. Each stage advances when it is empty or the stage
// after it moves, so bubbles close up under back-pressure. Registers must
// be written only while the pipeline is empty.
module pixel_point_operation_chain
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] pixel_out
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int unsigned NSTAGE = 9;
    localparam int unsigned W = ppoc_pkg::PIX_W;

    // configuration
    logic [ppoc_pkg::EN_W-1:0]          en_reg;
    ppoc_pkg::pix_t                     th_reg;
    ppoc_pkg::pix_t                     tl_reg;
    ppoc_pkg::pix_t                     hi_reg;
    ppoc_pkg::pix_t                     lo_reg;
    logic signed [ppoc_pkg::BIAS_W-1:0] bias_reg;
    logic [ppoc_pkg::GAIN_W-1:0]        gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= '0;
            th_reg   <= 8'd255;
            tl_reg   <= 8'd1;
            hi_reg   <= 8'd255;
            lo_reg   <= 8'd0;
            bias_reg <= '0;
            gain_reg <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ppoc_pkg::REG_OP_ENABLES:     en_reg   <= cfg_data[ppoc_pkg::EN_W-1:0];
                ppoc_pkg::REG_THRESHOLD_HIGH: th_reg   <= cfg_data[W-1:0];
                ppoc_pkg::REG_THRESHOLD_LOW:  tl_reg   <= cfg_data[W-1:0];
                ppoc_pkg::REG_OUT_HIGH:       hi_reg   <= cfg_data[W-1:0];
                ppoc_pkg::REG_OUT_LOW:        lo_reg   <= cfg_data[W-1:0];
                ppoc_pkg::REG_SCALE_BIAS:     bias_reg <= $signed(cfg_data[ppoc_pkg::BIAS_W-1:0]);
                ppoc_pkg::REG_SCALE_GAIN:     gain_reg <= cfg_data[ppoc_pkg::GAIN_W-1:0];
                default:                      ;
            endcase
        end
    end

    // pipeline control
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] adv;

    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 1: invert, threshold, range
    ppoc_pkg::pix_t a_pix_reg;
    ppoc_pkg::pix_t a_pix_next;

    always_comb
    begin
        a_pix_next = s_axis_tdata;
        if (en_reg[ppoc_pkg::EN_INVERT])
        begin
            a_pix_next = ~a_pix_next;
        end
        if (en_reg[ppoc_pkg::EN_THRESH] && !en_reg[ppoc_pkg::EN_RANGE]
            && !en_reg[ppoc_pkg::EN_WINDOW])
        begin
            a_pix_next = (a_pix_next >= th_reg) ? hi_reg : lo_reg;
        end
        if (en_reg[ppoc_pkg::EN_RANGE])
        begin
            if (a_pix_next < tl_reg || a_pix_next > th_reg)
            begin
                a_pix_next = lo_reg;
            end
        end
    end

    // stage 2: clamp and window products
    ppoc_pkg::pix_t b_pix_reg;
    logic [2*W-1:0] b_m0_reg;
    logic [2*W-1:0] b_m1_reg;
    ppoc_pkg::pix_t clamp_c;
    ppoc_pkg::pix_t dist_hi;
    ppoc_pkg::pix_t dist_lo;
    logic [2*W-1:0] b_m0_next;
    logic [2*W-1:0] b_m1_next;

    always_comb
    begin
        clamp_c = (a_pix_reg < tl_reg) ? tl_reg : a_pix_reg;
        clamp_c = (clamp_c > th_reg) ? th_reg : clamp_c;
        dist_hi = th_reg - clamp_c;
        dist_lo = clamp_c - tl_reg;
        b_m0_next = lo_reg * dist_hi;
        b_m1_next = hi_reg * dist_lo;
    end

    // stages 3 to 6: division, two quotient bits per stage
    ppoc_pkg::pix_t div_d;
    logic [2*W:0]   num_sum;
    assign div_d   = th_reg - tl_reg;
    assign num_sum = {1'b0, b_m0_reg} + {1'b0, b_m1_reg};

    ppoc_pkg::pix_t c_pix_reg;
    ppoc_pkg::pix_t d_pix_reg;
    ppoc_pkg::pix_t e_pix_reg;
    ppoc_pkg::pix_t f_pix_reg;
    logic [2*W-1:0] c_div_reg;
    logic [2*W-1:0] d_div_reg;
    logic [2*W-1:0] e_div_reg;
    logic [2*W-1:0] f_div_reg;
    logic [2*W-1:0] c_div_next;
    logic [2*W-1:0] d_div_next;
    logic [2*W-1:0] e_div_next;
    logic [2*W-1:0] f_div_next;

    assign c_div_next = ppoc_pkg::div_step(ppoc_pkg::div_step(num_sum[2*W-1:0], div_d), div_d);
    assign d_div_next = ppoc_pkg::div_step(ppoc_pkg::div_step(c_div_reg, div_d), div_d);
    assign e_div_next = ppoc_pkg::div_step(ppoc_pkg::div_step(d_div_reg, div_d), div_d);
    assign f_div_next = ppoc_pkg::div_step(ppoc_pkg::div_step(e_div_reg, div_d), div_d);

    // stage 7: window select, clip, bias
    localparam int unsigned SUM_W = ppoc_pkg::BIAS_W + 1;
    ppoc_pkg::pix_t           g_pix_reg;
    ppoc_pkg::pix_t           g_pix_next;
    logic signed [SUM_W-1:0]  g_sum_reg;
    logic signed [SUM_W-1:0]  g_sum_next;

    always_comb
    begin
        g_pix_next = f_pix_reg;
        if (en_reg[ppoc_pkg::EN_WINDOW])
        begin
            g_pix_next = (th_reg <= tl_reg) ? lo_reg : f_div_reg[W-1:0];
        end
        if (en_reg[ppoc_pkg::EN_CLIP])
        begin
            if (g_pix_next > hi_reg)
            begin
                g_pix_next = hi_reg;
            end
            if (g_pix_next < lo_reg)
            begin
                g_pix_next = lo_reg;
            end
        end
        g_sum_next = $signed({3'b000, g_pix_next, 4'b0000}) + SUM_W'(bias_reg);
    end

    // stage 8: gain multiply
    localparam int unsigned PROD_W = 32;
    ppoc_pkg::pix_t            h_pix_reg;
    logic signed [PROD_W-1:0]  h_prod_reg;
    logic signed [PROD_W-1:0]  h_prod_next;
    logic signed [PROD_W-1:0]  sum_ext;
    logic signed [PROD_W-1:0]  gain_ext;

    always_comb
    begin
        sum_ext     = PROD_W'(g_sum_reg);
        gain_ext    = $signed({{(PROD_W-ppoc_pkg::GAIN_W){1'b0}}, gain_reg});
        h_prod_next = sum_ext * gain_ext;
    end

    // stage 9: saturation
    ppoc_pkg::pix_t i_out_reg;
    ppoc_pkg::pix_t i_out_next;

    always_comb
    begin
        i_out_next = h_pix_reg;
        if (en_reg[ppoc_pkg::EN_SCALE])
        begin
            if (h_prod_reg[PROD_W-1])
            begin
                i_out_next = '0;
            end
            else if (|h_prod_reg[PROD_W-2:12+W])
            begin
                i_out_next = ppoc_pkg::PIXEL_MAX;
            end
            else
            begin
                i_out_next = h_prod_reg[12+W-1:12];
            end
        end
    end

    assign m_axis_tdata = i_out_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (adv[0]) a_pix_reg <= a_pix_next;
        if (adv[1])
        begin
            b_pix_reg <= a_pix_reg;
            b_m0_reg  <= b_m0_next;
            b_m1_reg  <= b_m1_next;
        end
        if (adv[2])
        begin
            c_pix_reg <= b_pix_reg;
            c_div_reg <= c_div_next;
        end
        if (adv[3])
        begin
            d_pix_reg <= c_pix_reg;
            d_div_reg <= d_div_next;
        end
        if (adv[4])
        begin
            e_pix_reg <= d_pix_reg;
            e_div_reg <= e_div_next;
        end
        if (adv[5])
        begin
            f_pix_reg <= e_pix_reg;
            f_div_reg <= f_div_next;
        end
        if (adv[6])
        begin
            g_pix_reg <= g_pix_next;
            g_sum_reg <= g_sum_next;
        end
        if (adv[7])
        begin
            h_pix_reg  <= g_pix_reg;
            h_prod_reg <= h_prod_next;
        end
        if (adv[8]) i_out_reg <= i_out_next;
    end

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted transaction did not enter first stage");

    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!(&valid_reg) || m_axis_tready))
        else $error("input ready with a full stalled pipeline");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> valid_reg[NSTAGE-1] && $stable(i_out_reg))
        else $error("stalled output stage changed");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - pixel point operation chain testbench
// Streams pixels through the chain under a range of register settings and
// checks every output pixel against an in-bench transform of the enabled
// stages. Both stream sides idle and stall at random. One phase holds the
// output side off for a long stretch so that the pipeline fills and stalls
// its input. Registers are only written while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ppoc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [ppoc_pkg::EN_W-1:0] DO_INV   = ppoc_pkg::EN_W'(1 << ppoc_pkg::EN_INVERT);
    localparam logic [ppoc_pkg::EN_W-1:0] DO_THR   = ppoc_pkg::EN_W'(1 << ppoc_pkg::EN_THRESH);
    localparam logic [ppoc_pkg::EN_W-1:0] DO_RNG   = ppoc_pkg::EN_W'(1 << ppoc_pkg::EN_RANGE);
    localparam logic [ppoc_pkg::EN_W-1:0] DO_WIN   = ppoc_pkg::EN_W'(1 << ppoc_pkg::EN_WINDOW);
    localparam logic [ppoc_pkg::EN_W-1:0] DO_CLIP  = ppoc_pkg::EN_W'(1 << ppoc_pkg::EN_CLIP);
    localparam logic [ppoc_pkg::EN_W-1:0] DO_SCALE = ppoc_pkg::EN_W'(1 << ppoc_pkg::EN_SCALE);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // register copies used for prediction
    logic [ppoc_pkg::EN_W-1:0]          cur_enables = '0;
    ppoc_pkg::pix_t                     cur_th = 8'd255;
    ppoc_pkg::pix_t                     cur_tl = 8'd1;
    ppoc_pkg::pix_t                     cur_hi = 8'd255;
    ppoc_pkg::pix_t                     cur_lo = 8'd0;
    logic signed [ppoc_pkg::BIAS_W-1:0] cur_bias = '0;
    logic [ppoc_pkg::GAIN_W-1:0]        cur_gain = 16'd256;

    ppoc_pkg::pix_t source_pixels[$];
    ppoc_pkg::pix_t expected_pixels[$];

    logic pixel_taken = 1'b0;
    logic calm = 1'b0;
    logic sink_blocked = 1'b0;
    logic hold_start = 1'b0;

    int error_count = 0;
    int pixels_in = 0;
    int pixels_checked = 0;
    int settings = 0;
    int stage_use[ppoc_pkg::EN_W];

    pixel_point_operation_chain dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(4_000_000);
        $display("Timeout: %0d pixels in, %0d checked", pixels_in, pixels_checked);
        $display("TEST FAILED");
        $finish;
    end

    function automatic ppoc_pkg::pix_t transform_pixel(input ppoc_pkg::pix_t pin);
        int unsigned p, c, th, tl, hi, lo;
        longint v;
        p  = pin;
        th = cur_th;
        tl = cur_tl;
        hi = cur_hi;
        lo = cur_lo;
        if (cur_enables[ppoc_pkg::EN_INVERT])
            p = int'(ppoc_pkg::PIXEL_MAX) - p;
        if (cur_enables[ppoc_pkg::EN_THRESH] && !cur_enables[ppoc_pkg::EN_RANGE]
            && !cur_enables[ppoc_pkg::EN_WINDOW])
            p = (p >= th) ? hi : lo;
        if (cur_enables[ppoc_pkg::EN_RANGE] && (p < tl || p > th))
            p = lo;
        if (cur_enables[ppoc_pkg::EN_WINDOW])
        begin
            if (th <= tl)
            begin
                p = lo;
            end
            else
            begin
                c = (p < tl) ? tl : p;
                c = (c > th) ? th : c;
                p = (lo * (th - c) + hi * (c - tl)) / (th - tl);
            end
        end
        if (cur_enables[ppoc_pkg::EN_CLIP])
        begin
            if (p > hi)
                p = hi;
            if (p < lo)
                p = lo;
        end
        if (cur_enables[ppoc_pkg::EN_SCALE])
        begin
            v = (longint'(p) * 16 + longint'(cur_bias)) * longint'(cur_gain);
            if (v < 0)
                p = 0;
            else if ((v >>> 12) > longint'(ppoc_pkg::PIXEL_MAX))
                p = int'(ppoc_pkg::PIXEL_MAX);
            else
                p = unsigned'(32'(v >>> 12));
        end
        return ppoc_pkg::pix_t'(p);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // source side driver
    always @(negedge clk)
    begin
        if (!(s_axis_tvalid && !pixel_taken))
        begin
            if (source_pixels.size() != 0 && (calm || $urandom_range(99) >= 28))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= source_pixels[0];
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side ready
    always @(negedge clk)
    begin
        m_axis_tready <= !sink_blocked && (calm || $urandom_range(99) >= 28);
    end

    // long output stall, counted here while the source keeps offering
    initial
    begin : back_pressure
        wait (hold_start);
        sink_blocked = 1'b1;
        repeat (300) @(posedge clk);
        sink_blocked = 1'b0;
    end

    // transaction monitor: results first, then new pixels
    always @(posedge clk)
    begin : monitor
        ppoc_pkg::pix_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                note_error($sformatf("unexpected output pixel %0d", m_axis_tdata));
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (m_axis_tdata !== want)
                    note_error($sformatf("pixel_out expected %0d got %0d", want, m_axis_tdata));
            end
        end
        pixel_taken = s_axis_tvalid && s_axis_tready;
        if (pixel_taken)
        begin
            expected_pixels.push_back(transform_pixel(s_axis_tdata));
            void'(source_pixels.pop_front());
            pixels_in++;
            for (int b = 0; b < ppoc_pkg::EN_W; b++)
                stage_use[b] += cur_enables[b];
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val, input int w);
        logic [15:0] mask;
        logic [15:0] data;
        mask = 16'((32'd1 << w) - 1);
        data = (16'($urandom) & ~mask) | (val & mask);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        case (idx)
            ppoc_pkg::REG_OP_ENABLES:     cur_enables = data[ppoc_pkg::EN_W-1:0];
            ppoc_pkg::REG_THRESHOLD_HIGH: cur_th      = data[ppoc_pkg::PIX_W-1:0];
            ppoc_pkg::REG_THRESHOLD_LOW:  cur_tl      = data[ppoc_pkg::PIX_W-1:0];
            ppoc_pkg::REG_OUT_HIGH:       cur_hi      = data[ppoc_pkg::PIX_W-1:0];
            ppoc_pkg::REG_OUT_LOW:        cur_lo      = data[ppoc_pkg::PIX_W-1:0];
            ppoc_pkg::REG_SCALE_BIAS:     cur_bias    = data[ppoc_pkg::BIAS_W-1:0];
            ppoc_pkg::REG_SCALE_GAIN:     cur_gain    = data[ppoc_pkg::GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [ppoc_pkg::EN_W-1:0] en, input ppoc_pkg::pix_t th,
                            input ppoc_pkg::pix_t tl, input ppoc_pkg::pix_t hi,
                            input ppoc_pkg::pix_t lo,
                            input logic signed [ppoc_pkg::BIAS_W-1:0] bias,
                            input logic [ppoc_pkg::GAIN_W-1:0] gain);
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, 16'($urandom), 16);
        write_reg(ppoc_pkg::REG_OP_ENABLES, 16'(en), ppoc_pkg::EN_W);
        write_reg(ppoc_pkg::REG_THRESHOLD_HIGH, 16'(th), ppoc_pkg::PIX_W);
        write_reg(ppoc_pkg::REG_THRESHOLD_LOW, 16'(tl), ppoc_pkg::PIX_W);
        write_reg(ppoc_pkg::REG_OUT_HIGH, 16'(hi), ppoc_pkg::PIX_W);
        write_reg(ppoc_pkg::REG_OUT_LOW, 16'(lo), ppoc_pkg::PIX_W);
        write_reg(ppoc_pkg::REG_SCALE_BIAS, 16'(bias), ppoc_pkg::BIAS_W);
        write_reg(ppoc_pkg::REG_SCALE_GAIN, gain, ppoc_pkg::GAIN_W);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic drain_pipeline();
        int n;
        n = 0;
        while ((source_pixels.size() != 0 || expected_pixels.size() != 0) && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    function automatic ppoc_pkg::pix_t pick_level();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return ppoc_pkg::PIXEL_MAX;
            default: return ppoc_pkg::pix_t'($urandom_range(255));
        endcase
    endfunction

    function automatic logic signed [ppoc_pkg::BIAS_W-1:0] pick_bias();
        case ($urandom_range(5))
            0:       return 14'sh2000;
            1:       return 14'sh1FFF;
            2:       return '0;
            3:       return ppoc_pkg::BIAS_W'($urandom);
            default: return ppoc_pkg::BIAS_W'($signed($urandom_range(4095)) - 2048);
        endcase
    endfunction

    function automatic logic [ppoc_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'd256;
            3:       return ppoc_pkg::GAIN_W'($urandom);
            default: return ppoc_pkg::GAIN_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic ppoc_pkg::pix_t pick_pixel();
        case ($urandom_range(9))
            0:       return cur_tl;
            1:       return cur_th;
            2:       return cur_tl - 8'd1;
            3:       return cur_th + 8'd1;
            4:       return $urandom_range(1) ? ppoc_pkg::PIXEL_MAX : 8'd0;
            default: return ppoc_pkg::pix_t'($urandom_range(255));
        endcase
    endfunction

    initial
    begin : stimulus
        int queued;
        int n;
        int round;
        queued = 0;
        round = 0;
        foreach (stage_use[b])
            stage_use[b] = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: every stage off
        source_pixels.push_back(8'h00);
        source_pixels.push_back(8'hFF);
        source_pixels.push_back(8'h55);
        source_pixels.push_back(8'hAA);
        drain_pipeline();

        set_regs(DO_INV | DO_THR, 8'd128, 8'd1, 8'd200, 8'd10, 14'sd0, 16'd256);
        source_pixels.push_back(8'd127);
        source_pixels.push_back(8'd128);
        drain_pipeline();

        // threshold is bypassed while range is on
        set_regs(DO_THR | DO_RNG, 8'd100, 8'd50, 8'd255, 8'd7, 14'sd0, 16'd256);
        source_pixels.push_back(8'd49);
        source_pixels.push_back(8'd75);
        source_pixels.push_back(8'd101);
        drain_pipeline();

        // empty range
        set_regs(DO_RNG, 8'd100, 8'd200, 8'd255, 8'd7, 14'sd0, 16'd256);
        source_pixels.push_back(8'd150);
        drain_pipeline();

        set_regs(DO_THR | DO_WIN, 8'd220, 8'd20, 8'd255, 8'd0, 14'sd0, 16'd256);
        source_pixels.push_back(8'd0);
        source_pixels.push_back(8'd120);
        source_pixels.push_back(8'd255);
        drain_pipeline();

        // degenerate window
        set_regs(DO_WIN | DO_CLIP, 8'd80, 8'd80, 8'd200, 8'd30, 14'sd0, 16'd256);
        source_pixels.push_back(8'd80);
        drain_pipeline();

        // clip bounds crossed
        set_regs(DO_CLIP, 8'd255, 8'd1, 8'd10, 8'd200, 14'sd0, 16'd256);
        source_pixels.push_back(8'd100);
        drain_pipeline();

        set_regs(DO_CLIP, 8'd255, 8'd1, 8'd200, 8'd50, 14'sd0, 16'd256);
        source_pixels.push_back(8'd20);
        source_pixels.push_back(8'd250);
        drain_pipeline();

        // scale below zero, above full scale, then 1.5 with a bias of one
        set_regs(DO_SCALE, 8'd255, 8'd1, 8'd255, 8'd0, 14'sh2000, 16'hFFFF);
        source_pixels.push_back(8'd255);
        drain_pipeline();
        set_regs(DO_SCALE, 8'd255, 8'd1, 8'd255, 8'd0, 14'sh1FFF, 16'hFFFF);
        source_pixels.push_back(8'd0);
        drain_pipeline();
        set_regs(DO_SCALE, 8'd255, 8'd1, 8'd255, 8'd0, 14'sd16, 16'd384);
        source_pixels.push_back(8'd100);
        drain_pipeline();

        // write to the unused index must leave the settings alone
        write_reg(REG_UNUSED, 16'hFFFF, 16);
        set_regs(6'h3F, 8'd200, 8'd40, 8'd230, 8'd20, -14'sd64, 16'd300);
        source_pixels.push_back(8'd0);
        source_pixels.push_back(8'd255);
        drain_pipeline();

        while (queued < 1600)
        begin
            set_regs(ppoc_pkg::EN_W'($urandom_range(63)), pick_level(), pick_level(),
                     pick_level(), pick_level(), pick_bias(), pick_gain());
            n = $urandom_range(20, 60);
            if (round == 4)
            begin
                calm = 1'b1;
                hold_start = 1'b1;
                n = 160;
            end
            else if (round == 9)
            begin
                calm = 1'b1;
                n = 100;
            end
            for (int i = 0; i < n; i++)
                source_pixels.push_back(pick_pixel());
            queued += n;
            drain_pipeline();
            calm = 1'b0;
            round++;
        end

        repeat (30) @(posedge clk);
        if (expected_pixels.size() != 0)
            note_error($sformatf("%0d output pixels never arrived", expected_pixels.size()));

        $display("Streamed %0d pixels under %0d register settings, %0d outputs checked",
                 pixels_in, settings, pixels_checked);
        $display("Pixels per stage: inv %0d thr %0d rng %0d win %0d clip %0d scale %0d",
                 stage_use[ppoc_pkg::EN_INVERT], stage_use[ppoc_pkg::EN_THRESH],
                 stage_use[ppoc_pkg::EN_RANGE], stage_use[ppoc_pkg::EN_WINDOW],
                 stage_use[ppoc_pkg::EN_CLIP], stage_use[ppoc_pkg::EN_SCALE]);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d errors", error_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
